/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DHC_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("dhc assertion failed");
`define DHC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dhc implication failed");
`else
`define DHC_ASSERT(label, clk, rst, expr)
`define DHC_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/dhc_pkg.sv */
// ----------------------------------------------------------------------------
// dhc_pkg
// Types, constants and the ramp rounding function of the hue colormap.
// ----------------------------------------------------------------------------
`default_nettype none

package dhc_pkg;

  localparam int LEVEL_W    = 13;
  localparam int HUE_MOD_W  = 9;
  localparam int CHAN_W     = 8;
  localparam int RAMP_W     = 6;
  localparam int SECTOR_DEG = 60;
  localparam int HUE_WRAP   = 360;
  localparam int FULL_SCALE = 255;
  localparam int HUE_SPAN   = 240;
  localparam int LEVELS_RST = 64;

  // Control and partial results carried from cell to cell.
  typedef struct packed {
    logic                 valid;
    logic                 clamped;
    logic [LEVEL_W-1:0]   rem;
    logic [HUE_MOD_W-1:0] hmod;
  } dhc_cell_t;

  // round(255 * k / 60) = round(17 * k / 4), ties to even; k in 0..60.
  function automatic logic [CHAN_W-1:0] ramp(input logic [RAMP_W-1:0] k);
    logic [RAMP_W+3:0] n;
    logic [CHAN_W-1:0] q;
    n = {k, 4'b0000} + {4'b0000, k};
    q = n[RAMP_W+3:2];
    if ((n[1:0] == 2'd3) || ((n[1:0] == 2'd2) && q[0])) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dhc_if.sv */
// ----------------------------------------------------------------------------
// dhc_if
// Valid/ready channels: disparity samples in, colored pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhc_disp_if #(
  parameter int DISPARITY_WIDTH = 16
);
  logic                              valid;
  logic                              ready;
  logic signed [DISPARITY_WIDTH-1:0] disparity;

  modport source (output valid, output disparity, input ready);
  modport sink   (input valid, input disparity, output ready);
endinterface

interface dhc_pix_if;
  logic                       valid;
  logic                       ready;
  logic [dhc_pkg::CHAN_W-1:0] blue;
  logic [dhc_pkg::CHAN_W-1:0] green;
  logic [dhc_pkg::CHAN_W-1:0] red;
  logic                       hue_clamped;

  modport source (output valid, output blue, output green, output red,
                  output hue_clamped, input ready);
  modport sink   (input valid, input blue, input green, input red,
                  input hue_clamped, output ready);
endinterface

`default_nettype wire

/* rtl/core/dhc_div_cell.sv */
// ----------------------------------------------------------------------------
// dhc_div_cell
// One restoring-division step: one quotient bit, hue kept modulo 360.
// ----------------------------------------------------------------------------
`default_nettype none

module dhc_div_cell #(
  parameter int NUM_W = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire logic [dhc_pkg::LEVEL_W-1:0]  levels,
  input  wire dhc_pkg::dhc_cell_t           in_cell,
  input  wire logic [NUM_W-1:0]             in_num,
  output      dhc_pkg::dhc_cell_t           out_cell,
  output      logic [NUM_W-1:0]             out_num
);

  logic [dhc_pkg::LEVEL_W:0]     trial;
  logic [dhc_pkg::LEVEL_W:0]     lev_ext;
  logic [dhc_pkg::LEVEL_W:0]     diff;
  logic                          qbit;
  logic [dhc_pkg::HUE_MOD_W:0]   hm2;
  dhc_pkg::dhc_cell_t            cell_next;

  always_comb begin
    // Shift in the next numerator bit, subtract the divisor if it fits.
    trial   = {in_cell.rem, in_num[NUM_W-1]};
    lev_ext = {1'b0, levels};
    diff    = trial - lev_ext;
    qbit    = (trial >= lev_ext);
    // Quotient so far, reduced modulo the hue circle.
    hm2     = {in_cell.hmod, qbit};
    cell_next.valid   = in_cell.valid;
    cell_next.clamped = in_cell.clamped;
    cell_next.rem     = qbit ? diff[dhc_pkg::LEVEL_W-1:0] : trial[dhc_pkg::LEVEL_W-1:0];
    if (hm2 >= (dhc_pkg::HUE_MOD_W+1)'(dhc_pkg::HUE_WRAP)) begin
      cell_next.hmod = dhc_pkg::HUE_MOD_W'(hm2 - (dhc_pkg::HUE_MOD_W+1)'(dhc_pkg::HUE_WRAP));
    end else begin
      cell_next.hmod = hm2[dhc_pkg::HUE_MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cell.valid <= 1'b0;
    end else if (advance) begin
      out_cell.valid <= cell_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cell.clamped <= cell_next.clamped;
      out_cell.rem     <= cell_next.rem;
      out_cell.hmod    <= cell_next.hmod;
      out_num          <= {in_num[NUM_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dhc_shade.sv */
// ----------------------------------------------------------------------------
// dhc_shade
// Map a hue in 0..359 to a fully saturated BGR pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module dhc_shade (
  input  wire logic [dhc_pkg::HUE_MOD_W-1:0] hmod,
  output      logic [dhc_pkg::CHAN_W-1:0]    blue,
  output      logic [dhc_pkg::CHAN_W-1:0]    green,
  output      logic [dhc_pkg::CHAN_W-1:0]    red
);

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  localparam logic [dhc_pkg::HUE_MOD_W-1:0] DEG = dhc_pkg::HUE_MOD_W'(dhc_pkg::SECTOR_DEG);
  localparam logic [dhc_pkg::HUE_MOD_W-1:0] DEG2 =
    dhc_pkg::HUE_MOD_W'(2 * dhc_pkg::SECTOR_DEG);
  localparam logic [dhc_pkg::HUE_MOD_W-1:0] DEG3 =
    dhc_pkg::HUE_MOD_W'(3 * dhc_pkg::SECTOR_DEG);
  localparam logic [dhc_pkg::HUE_MOD_W-1:0] DEG4 =
    dhc_pkg::HUE_MOD_W'(4 * dhc_pkg::SECTOR_DEG);
  localparam logic [dhc_pkg::HUE_MOD_W-1:0] DEG5 =
    dhc_pkg::HUE_MOD_W'(5 * dhc_pkg::SECTOR_DEG);
  localparam logic [dhc_pkg::CHAN_W-1:0]    MAX = dhc_pkg::CHAN_W'(dhc_pkg::FULL_SCALE);
  localparam logic [dhc_pkg::CHAN_W-1:0]    MIN = '0;

  sector_t                         sector;
  logic [dhc_pkg::HUE_MOD_W-1:0]   base;
  logic [dhc_pkg::HUE_MOD_W-1:0]   rest_w;
  logic [dhc_pkg::RAMP_W-1:0]      rest;
  logic [dhc_pkg::CHAN_W-1:0]      t_ramp;
  logic [dhc_pkg::CHAN_W-1:0]      q_ramp;

  always_comb begin
    if (hmod >= DEG5) begin
      sector = SEC_MAG_RED;
      base   = DEG5;
    end else if (hmod >= DEG4) begin
      sector = SEC_BLU_MAG;
      base   = DEG4;
    end else if (hmod >= DEG3) begin
      sector = SEC_CYN_BLU;
      base   = DEG3;
    end else if (hmod >= DEG2) begin
      sector = SEC_GRN_CYN;
      base   = DEG2;
    end else if (hmod >= DEG) begin
      sector = SEC_YEL_GRN;
      base   = DEG;
    end else begin
      sector = SEC_RED_YEL;
      base   = '0;
    end
    rest_w = hmod - base;
    rest   = rest_w[dhc_pkg::RAMP_W-1:0];
    t_ramp = dhc_pkg::ramp(rest);
    q_ramp = dhc_pkg::ramp(dhc_pkg::RAMP_W'(dhc_pkg::SECTOR_DEG) - rest);

    unique case (sector)
      SEC_RED_YEL: begin blue = MIN;    green = t_ramp; red = MAX;    end
      SEC_YEL_GRN: begin blue = MIN;    green = MAX;    red = q_ramp; end
      SEC_GRN_CYN: begin blue = t_ramp; green = MAX;    red = MIN;    end
      SEC_CYN_BLU: begin blue = MAX;    green = q_ramp; red = MIN;    end
      SEC_BLU_MAG: begin blue = MAX;    green = MIN;    red = t_ramp; end
      default:     begin blue = q_ramp; green = MIN;    red = MAX;    end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/disparity_hue_colormap.sv */
// Registered path: stage 0, stage 1, the NUM_W division cells and the output
//   register, where NUM_W = max(DISPARITY_WIDTH, 13) + 9.
// Throughput: one transaction per cycle; the whole pipeline holds while an
//   output result is stalled.
// Reset clears every stage valid bit and sets num_levels to 64.
// ----------------------------------------------------------------------------
// disparity_hue_colormap
// Color-code signed disparity samples on a hue ramp from blue (far) to red
// (near) using a pipelined chain of restoring-division cells.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module disparity_hue_colormap #(
  parameter int DISPARITY_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [dhc_pkg::LEVEL_W-1:0]   cfg_wdata,
  dhc_disp_if.sink                           disp,
  dhc_pix_if.source                          pix
);

  // Signed width of num_levels - disparity, its magnitude, and the
  // numerator (magnitude * 240). One division cell per numerator bit.
  localparam int DIFF_W = ((DISPARITY_WIDTH > dhc_pkg::LEVEL_W) ?
                           DISPARITY_WIDTH : dhc_pkg::LEVEL_W) + 2;
  localparam int MAG_W  = DIFF_W - 1;
  localparam int NUM_W  = MAG_W + 8;

  // Effective divisor: a written zero is treated as one.
  logic [dhc_pkg::LEVEL_W-1:0] levels;

  logic                        advance;

  // Stage 0: difference and clamp.
  logic signed [DIFF_W-1:0]    lev_s;
  logic signed [DIFF_W-1:0]    disp_s;
  logic signed [DIFF_W-1:0]    diff;
  logic                        s0_valid;
  logic                        s0_clamp;
  logic [MAG_W-1:0]            s0_mag;

  // Stage 1: numerator.
  logic                        s1_valid;
  logic                        s1_clamp;
  logic [NUM_W-1:0]            s1_num;
  logic [NUM_W-1:0]            num_next;

  // Division chain.
  dhc_pkg::dhc_cell_t          chain_cell [0:NUM_W];
  logic [NUM_W-1:0]            chain_num  [0:NUM_W];

  // Output register.
  logic                        out_valid;
  logic                        out_clamp;
  logic [dhc_pkg::CHAN_W-1:0]  out_blue;
  logic [dhc_pkg::CHAN_W-1:0]  out_green;
  logic [dhc_pkg::CHAN_W-1:0]  out_red;
  logic [dhc_pkg::CHAN_W-1:0]  shade_blue;
  logic [dhc_pkg::CHAN_W-1:0]  shade_green;
  logic [dhc_pkg::CHAN_W-1:0]  shade_red;

  // Advance every stage together unless a finished pixel is held.
  assign advance    = !out_valid || pix.ready;
  assign disp.ready = advance;

  // Configuration register; write only while no transaction is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= dhc_pkg::LEVEL_W'(dhc_pkg::LEVELS_RST);
    end else if (cfg_wen) begin
      levels <= (cfg_wdata == '0) ? dhc_pkg::LEVEL_W'(1) : cfg_wdata;
    end
  end

  // Form num_levels - disparity; a negative difference clamps hue to zero.
  always_comb begin
    lev_s  = DIFF_W'(signed'({1'b0, levels}));
    disp_s = DIFF_W'(disp.disparity);
    diff   = lev_s - disp_s;
    // Multiply by 240 as (x << 8) - (x << 4).
    num_next = {s0_mag, 8'd0} - {4'd0, s0_mag, 4'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
    end else if (advance) begin
      s0_valid  <= disp.valid;
      s1_valid  <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_clamp <= diff[DIFF_W-1];
      s0_mag   <= diff[DIFF_W-1] ? '0 : diff[MAG_W-1:0];
      s1_clamp <= s0_clamp;
      s1_num   <= num_next;
    end
  end

  // Seed the chain: empty remainder, zero quotient.
  always_comb begin
    chain_cell[0].valid   = s1_valid;
    chain_cell[0].clamped = s1_clamp;
    chain_cell[0].rem     = '0;
    chain_cell[0].hmod    = '0;
    chain_num[0]          = s1_num;
  end

  // One quotient bit per cell, most significant first.
  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    dhc_div_cell #(
      .NUM_W (NUM_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .levels   (levels),
      .in_cell  (chain_cell[i]),
      .in_num   (chain_num[i]),
      .out_cell (chain_cell[i+1]),
      .out_num  (chain_num[i+1])
    );
  end

  // Hue modulo 360 leaves the chain; turn it into a color.
  dhc_shade u_shade (
    .hmod  (chain_cell[NUM_W].hmod),
    .blue  (shade_blue),
    .green (shade_green),
    .red   (shade_red)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chain_cell[NUM_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_clamp <= chain_cell[NUM_W].clamped;
      out_blue  <= shade_blue;
      out_green <= shade_green;
      out_red   <= shade_red;
    end
  end

  assign pix.valid       = out_valid;
  assign pix.blue        = out_blue;
  assign pix.green       = out_green;
  assign pix.red         = out_red;
  assign pix.hue_clamped = out_clamp;

  // A clamped hue must come out pure red.
  `DHC_ASSERT_IMP(a_clamp_red, clk, rst, out_valid && out_clamp,
    (out_blue == '0) && (out_green == '0) && (out_red == 8'd255))
  // Full value: some channel is always at full scale.
  `DHC_ASSERT_IMP(a_full_value, clk, rst, out_valid,
    (out_blue == 8'd255) || (out_green == 8'd255) || (out_red == 8'd255))
  // Full saturation: some channel is always zero.
  `DHC_ASSERT_IMP(a_full_sat, clk, rst, out_valid,
    (out_blue == '0) || (out_green == '0) || (out_red == '0))
  // The divisor can never be zero.
  `DHC_ASSERT(a_levels_nonzero, clk, rst, levels != '0)

endmodule

`default_nettype wire

/* tb/sv/disparity_hue_colormap_checker.sv */
// ----------------------------------------------------------------------------
// disparity_hue_colormap_checker
// Watches the num_levels port and both channels of the hue colormap,
// predicts one BGR pixel per accepted disparity and compares each output
// transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module disparity_hue_colormap_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [dhc_pkg::LEVEL_W-1:0]   cfg_wdata,
  dhc_disp_if                           disp,
  dhc_pix_if                            pix,
  output int                            errors,
  output int                            pending,
  output int                            pixels_checked,
  output int                            clamped_count,
  output logic [5:0]                    sectors_hit
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECTORS    = 6;
  localparam int MAX_PRINTS = 40;
  localparam logic [dhc_pkg::CHAN_W-1:0] CHAN_MAX = dhc_pkg::CHAN_W'(dhc_pkg::FULL_SCALE);

  typedef enum int {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } hue_sector_e;

  typedef struct {
    logic signed [15:0]            disparity;
    logic [dhc_pkg::LEVEL_W-1:0]   levels;
    hue_sector_e                   sector;
    logic [dhc_pkg::CHAN_W-1:0]    blue;
    logic [dhc_pkg::CHAN_W-1:0]    green;
    logic [dhc_pkg::CHAN_W-1:0]    red;
    logic                          clamped;
  } pixel_t;

  logic [dhc_pkg::LEVEL_W-1:0] levels;
  pixel_t                      pending_pixels [$];

  // round(255*k/60) with ties to even, saturated at full scale
  function automatic logic [dhc_pkg::CHAN_W-1:0] ramp_round(input int k);
    int n;
    int q;
    n = 17 * k;
    q = n / 4;
    if ((n % 4 == 3) || ((n % 4 == 2) && (q % 2 == 1))) begin
      q++;
    end
    if (q > dhc_pkg::FULL_SCALE) begin
      q = dhc_pkg::FULL_SCALE;
    end
    return q[dhc_pkg::CHAN_W-1:0];
  endfunction

  function automatic pixel_t predict_pixel(input logic signed [15:0] d,
                                           input logic [dhc_pkg::LEVEL_W-1:0] lv);
    longint      span;
    longint      diff;
    longint      hue;
    int          rest;
    logic [7:0]  up;
    logic [7:0]  down;
    pixel_t      px;
    px.disparity = d;
    px.levels    = lv;
    // zero levels behaves as one level
    span = (lv == '0) ? 64'sd1 : longint'(lv);
    diff = span - longint'(d);
    px.clamped = 1'b0;
    if (diff < 0) begin
      hue        = 0;
      px.clamped = 1'b1;
    end else begin
      hue = (diff * dhc_pkg::HUE_SPAN) / span;
    end
    // very negative disparity wraps around the hue circle
    px.sector = hue_sector_e'(int'((hue / dhc_pkg::SECTOR_DEG) % SECTORS));
    rest      = int'(hue % dhc_pkg::SECTOR_DEG);
    up        = ramp_round(rest);
    down      = ramp_round(dhc_pkg::SECTOR_DEG - rest);
    case (px.sector)
      SEC_RED_YELLOW: begin
        px.blue = 8'd0;     px.green = up;       px.red = CHAN_MAX;
      end
      SEC_YELLOW_GREEN: begin
        px.blue = 8'd0;     px.green = CHAN_MAX; px.red = down;
      end
      SEC_GREEN_CYAN: begin
        px.blue = up;       px.green = CHAN_MAX; px.red = 8'd0;
      end
      SEC_CYAN_BLUE: begin
        px.blue = CHAN_MAX; px.green = down;     px.red = 8'd0;
      end
      SEC_BLUE_MAGENTA: begin
        px.blue = CHAN_MAX; px.green = 8'd0;     px.red = up;
      end
      default: begin
        px.blue = down;     px.green = 8'd0;     px.red = CHAN_MAX;
      end
    endcase
    return px;
  endfunction

  task automatic report_mismatch(input string what, input pixel_t px,
                                 input int got, input int want);
    if (errors < MAX_PRINTS) begin
      $display("[%0t] MISMATCH %s: disparity %0d levels %0d got %0d want %0d",
               $time, what, px.disparity, px.levels, got, want);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    pixel_t px;
    if (rst) begin
      levels = dhc_pkg::LEVEL_W'(dhc_pkg::LEVELS_RST);
      pending_pixels.delete();
      pending     <= 0;
      sectors_hit <= '0;
    end else begin
      if (cfg_wen) begin
        levels = cfg_wdata;
      end
      if (disp.valid && disp.ready) begin
        pending_pixels.push_back(predict_pixel(disp.disparity, levels));
      end
      if (pix.valid && pix.ready) begin
        if (pending_pixels.size() == 0) begin
          px = '{default: '0, sector: SEC_RED_YELLOW};
          report_mismatch("unexpected pixel", px, 0, 0);
        end else begin
          px = pending_pixels.pop_front();
          if (pix.blue !== px.blue) begin
            report_mismatch("blue", px, int'(pix.blue), int'(px.blue));
          end
          if (pix.green !== px.green) begin
            report_mismatch("green", px, int'(pix.green), int'(px.green));
          end
          if (pix.red !== px.red) begin
            report_mismatch("red", px, int'(pix.red), int'(px.red));
          end
          if (pix.hue_clamped !== px.clamped) begin
            report_mismatch("hue_clamped", px, int'(pix.hue_clamped),
                            int'(px.clamped));
          end
          pixels_checked++;
          if (px.clamped) begin
            clamped_count++;
          end
          sectors_hit[px.sector] <= 1'b1;
        end
      end
      pending <= pending_pixels.size();
    end
  end

endmodule

/* tb/sv/disparity_hue_colormap_tb.sv */
// ----------------------------------------------------------------------------
// disparity_hue_colormap_tb
// Drives disparity samples and num_levels settings into the hue colormap,
// throttles the pixel side, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module disparity_hue_colormap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DISP_W      = 16;
  localparam int LATENCY     = 27;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 180;

  logic                        clk;
  logic                        rst;
  logic                        cfg_wen;
  logic [dhc_pkg::LEVEL_W-1:0] cfg_wdata;

  dhc_disp_if #(.DISPARITY_WIDTH(DISP_W)) disp ();
  dhc_pix_if                              pix ();

  int         errors;
  int         pending;
  int         pixels_checked;
  int         clamped_count;
  logic [5:0] sectors_hit;

  // idle odds in percent per cycle, set per regime by the stimulus
  int send_idle;
  int recv_idle;
  // nonzero asks the pixel side to hold off for that many cycles
  int hold_request;
  int samples_sent;
  int settings_used;

  disparity_hue_colormap #(.DISPARITY_WIDTH(DISP_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .disp      (disp),
    .pix       (pix)
  );

  disparity_hue_colormap_checker pixel_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .disp           (disp),
    .pix            (pix),
    .errors         (errors),
    .pending        (pending),
    .pixels_checked (pixels_checked),
    .clamped_count  (clamped_count),
    .sectors_hit    (sectors_hit)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Pixel side: drop ready at random, or for a long stretch on request.
  // The hold count lives here so the sender keeps offering meanwhile.
  initial begin
    int hold_left;
    hold_left = 0;
    pix.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix.ready <= 1'b0;
      end else begin
        pix.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (disp.valid && disp.ready) || (pix.valid && pix.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no transaction for %0d cycles, %0d pixels pending",
             IDLE_LIMIT, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one sample, with random idle cycles ahead of it; hold valid
  // until the transaction completes.
  task automatic send_disparity(input logic signed [DISP_W-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      disp.valid <= 1'b0;
      @(posedge clk);
    end
    disp.valid     <= 1'b1;
    disp.disparity <= d;
    @(posedge clk);
    while (!disp.ready) begin
      @(posedge clk);
    end
    samples_sent++;
  endtask

  // Stop offering and wait until every predicted pixel has come out,
  // then let the pipeline settle.
  task automatic wait_drained();
    disp.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_levels(input logic [dhc_pkg::LEVEL_W-1:0] value);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    settings_used++;
  endtask

  // Mostly samples on the meaningful hue ramp, some on the clamp edge,
  // the rest anywhere in the 16-bit range.
  function automatic logic signed [DISP_W-1:0] random_disparity(
      input logic [dhc_pkg::LEVEL_W-1:0] lv);
    int span;
    int pick;
    int v;
    span = (lv == '0) ? 1 : int'(lv);
    pick = int'($urandom_range(99));
    if (pick < 50) begin
      v = int'($urandom_range(3 * span)) - 2 * span;
    end else if (pick < 65) begin
      v = span - 2 + int'($urandom_range(4));
    end else begin
      v = int'($urandom() & 32'hFFFF);
      if (v > 32767) begin
        v = v - 65536;
      end
    end
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return v[DISP_W-1:0];
  endfunction

  initial begin
    logic signed [DISP_W-1:0]    corner_cases [$];
    logic [dhc_pkg::LEVEL_W-1:0] phase_levels [PHASES];
    logic [dhc_pkg::LEVEL_W-1:0] lv;

    // Corner samples at the reset value of 64 levels:
    // range extremes, hue sector borders, the clamp edge, wrap-around,
    // ramp ties that round up and that stay even, alternating bits.
    corner_cases = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd64, 16'sd65,
                     16'sd63, 16'sd1, -16'sd1, 16'sd16, 16'sd32, 16'sd48,
                     -16'sd16, -16'sd64, -16'sd128, 16'sd58, 16'sd57,
                     16'sd21845, -16'sd21846, 16'sd66, 16'sd100, -16'sd200};
    // num_levels extremes, zero and the top of the 13-bit field
    phase_levels = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd64, 13'd2,
                     13'd3000, 13'd0, 13'd0};
    phase_levels[7] = dhc_pkg::LEVEL_W'($urandom_range(1, 4096));
    phase_levels[8] = dhc_pkg::LEVEL_W'($urandom_range(1, 4096));

    hold_request   = 0;
    samples_sent   = 0;
    settings_used  = 0;
    send_idle      = 8;
    recv_idle      = 46;
    rst            <= 1'b1;
    cfg_wen        <= 1'b0;
    cfg_wdata      <= '0;
    disp.valid     <= 1'b0;
    disp.disparity <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_cases[i]) begin
      send_disparity(corner_cases[i]);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      // sender light / receiver heavy, then swapped, then no idling
      if (phase < 3) begin
        send_idle = 8;
        recv_idle = 46;
      end else if (phase < 6) begin
        send_idle = 46;
        recv_idle = 8;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      lv = phase_levels[phase];
      write_levels(lv);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back-pressure: fill the pipeline and stall the input
        if (phase == 1 && n == 40) begin
          hold_request = HOLD_CYCLES;
        end
        // pause the sender until the pipeline runs dry
        if (phase == 4 && n == 90) begin
          wait_drained();
        end
        send_disparity(random_disparity(lv));
      end
    end

    wait_drained();

    $display("Summary: %0d disparity samples over %0d num_levels settings plus reset",
             samples_sent, settings_used);
    $display("Summary: %0d pixels checked, %0d clamped, hue sectors hit %b",
             pixels_checked, clamped_count, sectors_hit);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/dhc_pkg.sv
rtl/core/dhc_if.sv
rtl/core/dhc_div_cell.sv
rtl/core/dhc_shade.sv
rtl/core/disparity_hue_colormap.sv
tb/sv/disparity_hue_colormap_checker.sv
tb/sv/disparity_hue_colormap_tb.sv
